@@ rtl/core/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  localparam int unsigned PRI_W = 4;
  localparam int unsigned REC_W = 32;
  localparam int unsigned OCC_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [REC_W-1:0] rec;
  } entry_t;

  // Broadcast from the top level to every cell in the row.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/core/spq_if.sv @@
`default_nettype none

interface spq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [spq_pkg::PRI_W-1:0] priority_req;
  logic [spq_pkg::REC_W-1:0] record_id;

  modport source (output valid, mode, priority_req, record_id, input ready);
  modport sink   (input valid, mode, priority_req, record_id, output ready);
endinterface

interface spq_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [spq_pkg::REC_W-1:0] popped_id;
  logic [spq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, popped_id, occupancy, input ready);
  modport sink   (input valid, status, popped_id, occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
`default_nettype none

module spq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic            clk,
  input  wire logic [CW-1:0]   count,
  input  wire spq_pkg::op_t    op,
  input  wire logic            left_valid,
  input  wire logic            left_gt,
  input  wire spq_pkg::entry_t left_ent,
  input  wire spq_pkg::entry_t right_ent,
  output logic                 valid,
  output logic                 gt,
  output spq_pkg::entry_t      ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic            take_new;

  assign valid = count > CW'(IDX);
  // Strictly greater keeps equal priorities in arrival order.
  assign gt    = valid && (ent_r.pri > op.ent.pri);
  assign ent   = ent_r;

  // First slot that is empty or holds a larger priority, with the left
  // neighbour staying put.
  assign take_new = (!valid || gt) && left_valid && !left_gt;

  always_comb begin
    ent_nxt = ent_r;
    priority if (op.ins) begin
      priority if (left_gt) begin
        ent_nxt = left_ent;
      end else if (take_new) begin
        ent_nxt = op.ent;
      end else begin
        ent_nxt = ent_r;
      end
    end else if (op.pop) begin
      ent_nxt = right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/stable_sorted_priority_queue_core.sv @@
// Stable sorted priority queue, lowest priority value leaves first.
// in_ch carries one request: mode 0 inserts (priority_req, record_id),
// mode 1 pops the head. Entries of equal priority leave in arrival order.
// out_ch returns one result per request: status (done, pop on empty,
// insert on full), popped_id of the removed head (zero otherwise) and the
// occupancy after the request, modulo 32.
// Entries sit in a row of QUEUE_DEPTH cells; every cell compares its own
// priority against the new one in parallel and shifts right (insert) or
// left (pop) in the same cycle.
// Latency: the result appears in the cycle after the request is accepted.
// Throughput: one request per cycle while out_ch is taken.
// The result register decouples the sides: in_ch.ready stays high while
// that register is empty or being drained, and drops while a result
// waits on a stalled receiver.
// Reset empties the queue and drops any pending result; cell contents are
// left as they are and are never read above the occupancy.
`default_nettype none

module stable_sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  spq_pkg::status_t       status_r;
  spq_pkg::status_t       status_nxt;
  logic [spq_pkg::REC_W-1:0] popped_r;
  logic [spq_pkg::REC_W-1:0] popped_nxt;
  logic                   accept;
  logic                   is_pop;
  logic                   full;
  logic                   empty;
  spq_pkg::op_t           op;

  logic            cell_valid [QUEUE_DEPTH];
  logic            cell_gt    [QUEUE_DEPTH];
  spq_pkg::entry_t cell_ent   [QUEUE_DEPTH];

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pop      = in_ch.mode == spq_pkg::MODE_POP;
  assign full        = count_r == CW'(QUEUE_DEPTH);
  assign empty       = count_r == '0;

  assign op.ins     = accept && !is_pop && !full;
  assign op.pop     = accept && is_pop && !empty;
  assign op.ent.pri = in_ch.priority_req;
  assign op.ent.rec = in_ch.record_id;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            l_valid;
    logic            l_gt;
    spq_pkg::entry_t l_ent;
    spq_pkg::entry_t r_ent;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_ent   = '0;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_ent   = cell_ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = cell_ent[i+1];
    end

    spq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .count      (count_r),
      .op         (op),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .left_ent   (l_ent),
      .right_ent  (r_ent),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .ent        (cell_ent[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    priority if (op.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    status_nxt = status_r;
    popped_nxt = popped_r;
    if (accept) begin
      status_nxt = spq_pkg::ST_DONE;
      popped_nxt = '0;
      priority if (is_pop && empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else if (!is_pop && full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else if (is_pop) begin
        popped_nxt = cell_ent[0].rec;
      end else begin
        status_nxt = spq_pkg::ST_DONE;
      end
    end
    out_vld_nxt = accept || (out_vld_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  logic [spq_pkg::OCC_W-1:0] occ_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      occ_r <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = status_r;
  assign out_ch.popped_id = popped_r;
  assign out_ch.occupancy = occ_r;

endmodule

`default_nettype wire

@@ rtl/core/spq_checker.sv @@
`default_nettype none

module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [1:0]                out_status,
  input wire logic [spq_pkg::REC_W-1:0] out_popped_id,
  input wire logic [spq_pkg::OCC_W-1:0] out_occupancy
);

  localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(QUEUE_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_id) && $stable(out_occupancy))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != spq_pkg::ST_DONE |-> out_popped_id == '0)
    else $error("record number on a failed request");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_EMPTY |-> out_occupancy == '0)
    else $error("empty pop with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_FULL |-> out_occupancy == FULL_OCC)
    else $error("rejected insert below full occupancy");

endmodule

bind stable_sorted_priority_queue_core spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_popped_id (out_ch.popped_id),
  .out_occupancy (out_ch.occupancy)
);

`default_nettype wire
